// ===== hw/rtl/frame_slot_publish_table_macros.svh =====
// assertion helpers shared by the frame slot publish table
`ifndef FRAME_SLOT_PUBLISH_TABLE_MACROS_SVH
`define FRAME_SLOT_PUBLISH_TABLE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FSPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define FSPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fspt_pkg.sv =====
package fspt_pkg;

  // sizes
  localparam int SLOT_COUNT_DEF = 3;
  localparam int DIV_REG_COUNT  = 3;
  localparam int MASK_W         = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  // limits and frame sizes
  localparam logic [7:0] REF_MAX   = 8'd255;
  localparam logic [8:0] MAIN_W    = 9'd320;
  localparam logic [7:0] MAIN_H    = 8'd240;
  localparam logic [8:0] SMALL_W   = 9'd64;
  localparam logic [7:0] SMALL_H   = 8'd64;
  localparam logic [7:0] DIV_RESET = 8'd1;

  // command codes
  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_ENABLE     = 3'd1,
    CMD_DISABLE    = 3'd2,
    CMD_COMMIT     = 3'd3,
    CMD_BEGIN_READ = 3'd4,
    CMD_END_READ   = 3'd5,
    CMD_CLEAR      = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SLOT  = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_TORN      = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  // input word
  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  slot;
    logic [31:0] ticket;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  fire_mask;
    logic [7:0]  reference_count;
    logic [31:0] sequence_res;
    logic [8:0]  frame_width;
    logic [7:0]  frame_height;
    logic [31:0] frame_count;
    logic [31:0] frames_fired;
    logic [31:0] overrun_count;
    logic [2:0]  torn_mask;
  } out_word_t;

  // configuration write
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // operation request; inc, dec and commit already gated by slot validity
  typedef struct packed {
    logic       tick;
    logic       inc;
    logic       dec;
    logic       commit;
    logic [1:0] slot;
  } slot_req_t;

  // per-slot response; ref and sequence values after the operation
  typedef struct packed {
    logic [MASK_W-1:0] fire;
    logic              any_fire;
    logic [7:0]        ref_sel;
    logic [31:0]       seq_sel;
    logic              ref_was_max;
  } slot_rsp_t;

endpackage

// ===== hw/rtl/fspt_slots.sv =====
module fspt_slots
  import fspt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg,
  input  slot_req_t req,
  output slot_rsp_t rsp
);

  logic [7:0]  div_r     [SLOT_COUNT];
  logic [7:0]  cnt_r     [SLOT_COUNT];
  logic [7:0]  ref_r     [SLOT_COUNT];
  logic [31:0] seq_r     [SLOT_COUNT];
  logic [7:0]  cnt_nxt   [SLOT_COUNT];
  logic [7:0]  ref_nxt   [SLOT_COUNT];
  logic [31:0] seq_nxt   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] fire_vec;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    logic       hit;
    logic       cfg_hit;
    logic [7:0] cnt_inc;
    logic [7:0] div_wr;

    assign hit     = (32'(req.slot) == i);
    assign cfg_hit = cfg.we && (i < DIV_REG_COUNT) && (32'(cfg.index) == i);
    assign cnt_inc = cnt_r[i] + 8'd1;
    // a zero divider is stored as one
    assign div_wr  = (cfg.data == '0) ? DIV_RESET : cfg.data;

    // divider counter advances only for enabled slots
    always_comb begin
      fire_vec[i] = 1'b0;
      cnt_nxt[i]  = cnt_r[i];
      if (req.tick && ref_r[i] != '0) begin
        if (cnt_inc >= div_r[i]) begin
          fire_vec[i] = 1'b1;
          cnt_nxt[i]  = '0;
        end else begin
          cnt_nxt[i] = cnt_inc;
        end
      end
    end

    // saturating refcount
    always_comb begin
      ref_nxt[i] = ref_r[i];
      if (req.inc && hit && ref_r[i] != REF_MAX) begin
        ref_nxt[i] = ref_r[i] + 8'd1;
      end else if (req.dec && hit && ref_r[i] != '0) begin
        ref_nxt[i] = ref_r[i] - 8'd1;
      end
    end

    // publish sequence, wrapping
    assign seq_nxt[i] = (req.commit && hit) ? seq_r[i] + 32'd1 : seq_r[i];

    // slot state registers; the user must make configuration writes while idle (unchecked)
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[i] <= DIV_RESET;
        cnt_r[i] <= '0;
        ref_r[i] <= '0;
        seq_r[i] <= '0;
      end else begin
        ref_r[i] <= ref_nxt[i];
        seq_r[i] <= seq_nxt[i];
        if (cfg_hit) begin
          div_r[i] <= div_wr;
          cnt_r[i] <= '0;
        end else begin
          cnt_r[i] <= cnt_nxt[i];
        end
      end
    end
  end

  // fire mask covers only the low slots
  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < SLOT_COUNT) begin : g_on
      assign rsp.fire[m] = fire_vec[m];
    end else begin : g_off
      assign rsp.fire[m] = 1'b0;
    end
  end

  assign rsp.any_fire = |fire_vec;

  // selected slot view; ref and sequence values after the operation
  always_comb begin
    rsp.ref_sel     = '0;
    rsp.seq_sel     = '0;
    rsp.ref_was_max = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (32'(req.slot) == i) begin
        rsp.ref_sel     = ref_nxt[i];
        rsp.seq_sel     = seq_nxt[i];
        rsp.ref_was_max = (ref_r[i] == REF_MAX);
      end
    end
  end

endmodule

// ===== hw/rtl/frame_slot_publish_table.sv =====
// Frame slot publish table.
// Commands enter on in_word when start is high and busy is low; busy stays
// low, so a command may be issued in every cycle. Each command yields one
// result word on out_word, marked by out_valid for exactly one cycle.
// A command taken from in_word is held in the command register, worked on
// against the slot state, and its result is held in the result register.
// Throughput is one command per cycle, set by the single pass from the
// command register to the result register.
// The receiver cannot stall; results are never held or dropped.
// Divider registers are written via cfg_we / cfg_index / cfg_data; the user
// must do so only with no command in flight (not enforced). A write clears
// that slot's divider counter; indexes beyond the divider list are ignored.
// Synchronous reset (rst_n low) clears refcounts, counters, sequences and
// statistics, sets every divider to one and drops any pending result.
`include "frame_slot_publish_table_macros.svh"

module frame_slot_publish_table
  import fspt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        in_valid_r;
  in_word_t    in_word_r;
  logic        out_valid_r;
  out_word_t   out_word_r;
  out_word_t   out_word_nxt;
  logic [31:0] tick_total_r, tick_total_nxt;
  logic [31:0] fired_total_r, fired_total_nxt;
  logic [31:0] overruns_r, overruns_nxt;
  logic [MASK_W-1:0] torn_seen_r, torn_seen_nxt;

  cmd_t      cmd;
  logic      slot_ok;
  cfg_wr_t   cfg;
  slot_req_t req;
  slot_rsp_t rsp;

  assign busy = 1'b0;

  // command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r <= '0;
    end else if (start && !busy) begin
      in_word_r <= in_word;
    end
  end

  // decode
  assign cmd     = cmd_t'(in_word_r.command);
  assign slot_ok = (32'(in_word_r.slot) < SLOT_COUNT);

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign req.tick   = in_valid_r && (cmd == CMD_TICK);
  assign req.inc    = in_valid_r && slot_ok && (cmd == CMD_ENABLE);
  assign req.dec    = in_valid_r && slot_ok && (cmd == CMD_DISABLE);
  assign req.commit = in_valid_r && slot_ok && (cmd == CMD_COMMIT);
  assign req.slot   = in_word_r.slot;

  fspt_slots #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slots (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (cfg),
    .req  (req),
    .rsp  (rsp)
  );

  // result word and statistics
  always_comb begin
    status_t           st;
    logic              show;
    logic [MASK_W-1:0] fire;
    logic [8:0]        fw;
    logic [7:0]        fh;

    st              = ST_OK;
    show            = 1'b0;
    fire            = '0;
    fw              = '0;
    fh              = '0;
    tick_total_nxt  = tick_total_r;
    fired_total_nxt = fired_total_r;
    overruns_nxt    = overruns_r;
    torn_seen_nxt   = torn_seen_r;

    unique case (cmd)
      CMD_TICK: begin
        tick_total_nxt = tick_total_r + 32'd1;
        fire           = rsp.fire;
        if (rsp.any_fire) begin
          fired_total_nxt = fired_total_r + 32'd1;
        end
      end
      CMD_CLEAR: begin
        tick_total_nxt  = '0;
        fired_total_nxt = '0;
        overruns_nxt    = '0;
        torn_seen_nxt   = '0;
      end
      CMD_NOP: begin
      end
      CMD_ENABLE, CMD_DISABLE, CMD_COMMIT, CMD_BEGIN_READ, CMD_END_READ: begin
        if (!slot_ok) begin
          st = ST_BAD_SLOT;
        end else begin
          show = 1'b1;
          unique case (cmd)
            CMD_ENABLE: begin
              if (rsp.ref_was_max) begin
                st = ST_SATURATED;
              end
            end
            CMD_BEGIN_READ: begin
              if (rsp.ref_sel == '0 || rsp.seq_sel == '0) begin
                st = ST_NOT_READY;
              end else if (in_word_r.slot == '0) begin
                fw = MAIN_W;
                fh = MAIN_H;
              end else begin
                fw = SMALL_W;
                fh = SMALL_H;
              end
            end
            CMD_END_READ: begin
              if (rsp.seq_sel != in_word_r.ticket) begin
                st           = ST_TORN;
                overruns_nxt = overruns_r + 32'd1;
                for (int m = 0; m < MASK_W; m++) begin
                  if (32'(in_word_r.slot) == m) begin
                    torn_seen_nxt[m] = 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase

    out_word_nxt.status          = st;
    out_word_nxt.fire_mask       = fire;
    out_word_nxt.reference_count = show ? rsp.ref_sel : '0;
    out_word_nxt.sequence_res    = show ? rsp.seq_sel : '0;
    out_word_nxt.frame_width     = fw;
    out_word_nxt.frame_height    = fh;
    out_word_nxt.frame_count     = tick_total_nxt;
    out_word_nxt.frames_fired    = fired_total_nxt;
    out_word_nxt.overrun_count   = overruns_nxt;
    out_word_nxt.torn_mask       = torn_seen_nxt;
  end

  // statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_total_r  <= '0;
      fired_total_r <= '0;
      overruns_r    <= '0;
      torn_seen_r   <= '0;
    end else if (in_valid_r) begin
      tick_total_r  <= tick_total_nxt;
      fired_total_r <= fired_total_nxt;
      overruns_r    <= overruns_nxt;
      torn_seen_r   <= torn_seen_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  `FSPT_ASSERT_NEXT(a_word_to_result, in_valid_r, out_valid_r, "accepted word lost its result")
  `FSPT_ASSERT_NEXT(a_no_extra_result, !in_valid_r, !out_valid_r, "result without a word")
  `FSPT_ASSERT_NEXT(a_ticks_hold_idle, !in_valid_r, $stable(tick_total_r), "tick total moved idle")
  `FSPT_ASSERT_NEXT(a_torn_sticky, in_valid_r && cmd != CMD_CLEAR, (torn_seen_r & $past(torn_seen_r)) == $past(torn_seen_r), "torn mask lost a bit")

endmodule
